// File: src/bc_pkg.sv
`default_nettype none

package bc_pkg;

  // default field widths
  localparam int COORD_BITS_DEF       = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 14;

  // three vertices and the query point, three axes each
  localparam int NUM_IN_FIELDS = 12;

  // per-result flags leaving the divider pipeline
  typedef struct packed {
    logic valid;
    logic degenerate;
  } bc_tag_t;

endpackage

`default_nettype wire

// File: src/bc_geom.sv
`default_nettype none

module bc_geom #(
  parameter int COORD_BITS = bc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [bc_pkg::NUM_IN_FIELDS*COORD_BITS-1:0] in_data,
  output logic                             out_valid,
  // index 0: dot(n,n), 1..3: dot(n,na), dot(n,nb), dot(n,nc)
  output logic signed [4*COORD_BITS+7:0]   dots [4]
);

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;          // edge vector width
  localparam int PW = 2 * D + 1;      // cross product width
  localparam int BL = (PW + 1) / 2;   // low slice of the split operand
  localparam int BH = PW - BL;        // high slice of the split operand
  localparam int PP = 2 * PW;         // full product width
  localparam int NW = PP + 2;         // dot product width

  // edge vectors: minuend and subtrahend point (v0, v1, v2, p)
  localparam int DM [7] = '{1, 2, 2, 3, 0, 3, 3};
  localparam int DS [7] = '{0, 0, 1, 1, 2, 2, 0};
  // cross products: n, na, nb, nc from pairs of edge vectors
  localparam int CA [4] = '{0, 2, 4, 0};
  localparam int CB [4] = '{1, 3, 5, 6};

  logic [4:0]            vld;
  logic signed [D-1:0]   dif  [7][3];
  logic signed [PW-1:0]  crs  [4][3];
  logic signed [PW+BH-1:0] pph [4][3];
  logic signed [PW+BL:0] ppl  [4][3];
  logic signed [PP-1:0]  prd  [4][3];
  logic signed [NW-1:0]  dsum [4];

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // stage 1: coordinate differences
  for (genvar g = 0; g < 7; g++) begin : g_dif
    for (genvar a = 0; a < 3; a++) begin : g_ax
      logic [C-1:0] xm;
      logic [C-1:0] xs;
      assign xm = in_data[(DM[g]*3+a)*C +: C];
      assign xs = in_data[(DS[g]*3+a)*C +: C];
      always_ff @(posedge clk) begin
        if (en) begin
          dif[g][a] <= $signed({xm[C-1], xm}) - $signed({xs[C-1], xs});
        end
      end
    end
  end

  // stage 2: cross products
  for (genvar c = 0; c < 4; c++) begin : g_crs
    for (genvar i = 0; i < 3; i++) begin : g_ax
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      logic signed [2*D-1:0] m1;
      logic signed [2*D-1:0] m2;
      assign m1 = dif[CA[c]][J] * dif[CB[c]][K];
      assign m2 = dif[CA[c]][K] * dif[CB[c]][J];
      always_ff @(posedge clk) begin
        if (en) begin
          crs[c][i] <= $signed({m1[2*D-1], m1}) - $signed({m2[2*D-1], m2});
        end
      end
    end
  end

  // stage 3: partial products of n against each normal, operand split in two
  for (genvar d = 0; d < 4; d++) begin : g_pp
    for (genvar i = 0; i < 3; i++) begin : g_ax
      logic signed [BH-1:0] bh;
      logic signed [BL:0]   bl;
      assign bh = crs[d][i][PW-1:BL];
      assign bl = {1'b0, crs[d][i][BL-1:0]};
      always_ff @(posedge clk) begin
        if (en) begin
          pph[d][i] <= crs[0][i] * bh;
          ppl[d][i] <= crs[0][i] * bl;
        end
      end
    end
  end

  // stage 4: recombine partial products
  for (genvar d = 0; d < 4; d++) begin : g_prd
    for (genvar i = 0; i < 3; i++) begin : g_ax
      always_ff @(posedge clk) begin
        if (en) begin
          prd[d][i] <= $signed({pph[d][i], {BL{1'b0}}})
                     + $signed({{(BH-1){ppl[d][i][PW+BL]}}, ppl[d][i]});
        end
      end
    end
  end

  // stage 5: sum of the three axis products
  for (genvar d = 0; d < 4; d++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en) begin
        dsum[d] <= $signed({{2{prd[d][0][PP-1]}}, prd[d][0]})
                 + $signed({{2{prd[d][1][PP-1]}}, prd[d][1]})
                 + $signed({{2{prd[d][2][PP-1]}}, prd[d][2]});
      end
    end
    assign dots[d] = dsum[d];
  end

  assign out_valid = vld[4];

endmodule

`default_nettype wire

// File: src/bc_div.sv
`default_nettype none

module bc_div #(
  parameter int COORD_BITS       = bc_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = bc_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [4*COORD_BITS+7:0]    dots [4],
  output bc_pkg::bc_tag_t                   tag,
  output logic signed [WEIGHT_FRAC_BITS+3:0] weight [3]
);

  localparam int NW  = 4 * COORD_BITS + 8;
  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int QB  = F + 5;   // quotient bits: 4 integer, F+1 fraction
  localparam int QB1 = QB + 1;
  localparam int OW  = F + 4;

  localparam logic [QB-1:0] LIM_POS = QB'((1 << (F + 3)) - 1);
  localparam logic [QB-1:0] LIM_NEG = QB'(1 << (F + 3));
  localparam logic [OW-1:0] SAT_POS = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] SAT_NEG = {1'b1, {(OW-1){1'b0}}};

  // stage d1: magnitudes
  logic            v1;
  logic            deg1;
  logic [NW-1:0]   den1;
  logic [NW-1:0]   mag1 [3];
  logic [2:0]      neg1;

  // divide stages: index 0 is the initial remainder, index QB the quotient
  logic [QB:0]     vld_s;
  logic [QB:0]     deg_s;
  logic [NW-1:0]   den_s [QB+1];
  logic [QB:0]     neg_s [3];
  logic [QB:0]     sat_s [3];
  logic [NW-1:0]   rem_s [3][QB+1];
  logic [QB-1:0]   lq_s  [3][QB+1];

  // final stage
  logic            vf;
  logic            degf;
  logic [OW-1:0]   wres [3];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      vld_s <= '0;
      vf    <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      vld_s <= {vld_s[QB-1:0], v1};
      vf    <= vld_s[QB];
    end
  end

  // shared denominator and degenerate flag
  always_ff @(posedge clk) begin
    if (en) begin
      den1  <= dots[0];
      deg1  <= (dots[0] == '0);
      deg_s <= {deg_s[QB-1:0], deg1};
      degf  <= deg_s[QB];
      den_s[0] <= den1;
      for (int k = QB; k > 0; k--) begin
        den_s[k] <= den_s[k-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [NW-1:0] num;
    logic          sat_in;
    assign num    = dots[l+1];
    assign sat_in = {4'b0, mag1[l]} >= {den1, 4'b0};

    // d1: absolute value of the numerator
    // d2: saturation check and initial remainder
    always_ff @(posedge clk) begin
      if (en) begin
        neg1[l]     <= num[NW-1];
        mag1[l]     <= num[NW-1] ? (~num + NW'(1)) : num;
        neg_s[l]    <= {neg_s[l][QB-1:0], neg1[l]};
        sat_s[l]    <= {sat_s[l][QB-1:0], sat_in};
        rem_s[l][0] <= {4'b0, mag1[l][NW-1:4]};
        lq_s[l][0]  <= {mag1[l][3:0], {(F+1){1'b0}}};
      end
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [NW:0] t;
      logic [NW:0] t_sub;
      logic        ge;
      assign t     = {rem_s[l][k-1], lq_s[l][k-1][QB-1]};
      assign t_sub = t - {1'b0, den_s[k-1]};
      assign ge    = t >= {1'b0, den_s[k-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[l][k] <= ge ? t_sub[NW-1:0] : t[NW-1:0];
          lq_s[l][k]  <= {lq_s[l][k-1][QB-2:0], ge};
        end
      end
    end

    // round half away from zero, clamp, restore sign; zero when degenerate
    logic [QB:0]   q1;
    logic [QB-1:0] rr;
    logic [QB-1:0] mo;
    logic [OW-1:0] res;
    always_comb begin
      q1 = {1'b0, lq_s[l][QB]} + QB1'(1);
      rr = q1[QB:1];
      mo = rr;
      if (deg_s[QB]) begin
        res = '0;
      end else if (sat_s[l][QB]) begin
        res = neg_s[l][QB] ? SAT_NEG : SAT_POS;
      end else if (neg_s[l][QB]) begin
        mo  = (rr > LIM_NEG) ? LIM_NEG : rr;
        res = '0 - mo[OW-1:0];
      end else begin
        mo  = (rr > LIM_POS) ? LIM_POS : rr;
        res = mo[OW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wres[l] <= res;
      end
    end

    assign weight[l] = wres[l];
  end

  assign tag = '{valid: vf, degenerate: degf};

  // a degenerate triangle always gives zero weights
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (tag.valid && tag.degenerate) |->
      (weight[0] == '0 && weight[1] == '0 && weight[2] == '0))
    else $error("degenerate result with nonzero weight");

  // a stalled pipeline neither drops nor creates items
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(vld_s) && $stable(vf) && $stable(v1)))
    else $error("valid bits moved during stall");

endmodule

`default_nettype wire

// File: src/bc_skid.sv
`default_nettype none

module bc_skid #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             ov;
  logic [WIDTH-1:0] od;
  logic             sk_valid;
  logic [WIDTH-1:0] sk_data;

  // output register with one spare entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      ov       <= 1'b0;
      sk_valid <= 1'b0;
    end else if (out_ready || !ov) begin
      if (sk_valid) begin
        ov       <= 1'b1;
        sk_valid <= 1'b0;
      end else begin
        ov <= in_valid;
      end
    end else if (in_valid && !sk_valid) begin
      sk_valid <= 1'b1;
    end
  end

  // payload moves with the control above
  always_ff @(posedge clk) begin
    if (out_ready || !ov) begin
      od <= sk_valid ? sk_data : in_data;
    end else if (in_valid && !sk_valid) begin
      sk_data <= in_data;
    end
  end

  assign in_ready  = !sk_valid;
  assign out_valid = ov;
  assign out_data  = od;

  // the spare entry is only used behind a full output register
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> ov)
    else $error("spare entry full while output empty");

  // the spare entry stays put until the output drains
  a_skid_keep: assert property (@(posedge clk) disable iff (rst)
    (sk_valid && !out_ready) |=> (sk_valid && $stable(sk_data)))
    else $error("spare entry lost during stall");

endmodule

`default_nettype wire

// File: src/barycentric_coordinates.sv
// barycentric weights of a point against a 3d triangle
// s_axis: one transaction per query, three vertices and the point, signed
//   fixed point; accepted when s_axis_tvalid and s_axis_tready are high
// m_axis: one transaction per query, three signed weights with
//   WEIGHT_FRAC_BITS fraction bits in tdata and the degenerate flag in tuser
// throughput: one query per cycle with no bubbles as long as m_axis_tready
//   stays high
// pipeline: five stages of vector math, two stages of sign and range
//   handling, one restoring divide stage per quotient bit
//   (WEIGHT_FRAC_BITS + 5), one rounding stage and the output register
// reset: clears every valid bit; s_axis_tready is low while rst is high and
//   the pipeline starts empty
// stall: while m_axis_tready is low the result waiting at the output holds,
//   one more result lands in a spare register, then s_axis_tready falls and
//   the whole pipeline holds until the output drains
`default_nettype none

module barycentric_coordinates #(
  parameter int COORD_BITS       = bc_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = bc_pkg::WEIGHT_FRAC_BITS_DEF,
  localparam int IN_W  = ((bc_pkg::NUM_IN_FIELDS * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * (WEIGHT_FRAC_BITS + 4) + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, pt_x, pt_y, pt_z
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // weight_a, weight_b, weight_c
  output logic [OUT_W-1:0] m_axis_tdata,
  // degenerate
  output logic             m_axis_tuser
);

  localparam int NW = 4 * COORD_BITS + 8;
  localparam int OW = WEIGHT_FRAC_BITS + 4;
  localparam int SW = 3 * OW + 1;

  logic                 en;
  logic                 geom_valid;
  logic signed [NW-1:0] dots [4];
  bc_pkg::bc_tag_t      tag;
  logic signed [OW-1:0] weight [3];
  logic [SW-1:0]        res_data;
  logic [SW-1:0]        out_data;

  assign s_axis_tready = en && !rst;

  // cross and dot products
  bc_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata[bc_pkg::NUM_IN_FIELDS*COORD_BITS-1:0]),
    .out_valid (geom_valid),
    .dots      (dots)
  );

  // pipelined division, rounding and saturation
  bc_div #(
    .COORD_BITS       (COORD_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (geom_valid),
    .dots     (dots),
    .tag      (tag),
    .weight   (weight)
  );

  assign res_data = {tag.degenerate, weight[2], weight[1], weight[0]};

  // output register decoupling the stream sides
  bc_skid #(
    .WIDTH (SW)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tag.valid),
    .in_ready  (en),
    .in_data   (res_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = OUT_W'(out_data[SW-2:0]);
  assign m_axis_tuser = out_data[SW-1];

endmodule

`default_nettype wire

// File: tb/barycentric_coordinates_checker.sv
module barycentric_coordinates_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, pt_x, pt_y, pt_z
  input  logic [191:0]  s_axis_tdata,
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // weight_a, weight_b, weight_c
  input  logic [55:0]   m_axis_tdata,
  // degenerate
  input  logic          m_axis_tuser,
  output int            fail_cnt,
  output int            pending_cnt,
  output int            checked_cnt,
  output int            degen_cnt
);

  localparam int CB    = bc_pkg::COORD_BITS_DEF;
  localparam int WF    = bc_pkg::WEIGHT_FRAC_BITS_DEF;
  localparam int OW    = WF + 4;
  localparam int LIM   = 1 << (WF + 3);
  localparam int NFLD  = bc_pkg::NUM_IN_FIELDS;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  typedef struct packed {
    logic [OW-1:0] wa;
    logic [OW-1:0] wb;
    logic [OW-1:0] wc;
    logic          degen;
  } weight_set_t;

  weight_set_t weights_q[$];
  int          fails;
  int          checked;
  int          degens;

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
    checked_cnt = 0;
    degen_cnt   = 0;
    fails       = 0;
    checked     = 0;
    degens      = 0;
  end

  function automatic vec3_t sub3(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec3_t cross3(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // exact dot product, cross terms need about 72 bits
  function automatic logic signed [127:0] dot3(input vec3_t a, input vec3_t b);
    logic signed [127:0] ax, ay, az, bx, by, bz;
    ax = a.x;
    ay = a.y;
    az = a.z;
    bx = b.x;
    by = b.y;
    bz = b.z;
    return ax * bx + ay * by + az * bz;
  endfunction

  // num/den in q3.14, nearest with ties away from zero, saturated
  function automatic logic [OW-1:0] scale_ratio(input logic signed [127:0] num,
                                                input logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] quo;
    logic signed [127:0] rnd;
    logic                neg;
    neg = num[127];
    mag = neg ? -num : num;
    if (mag >= (den <<< 4)) begin
      rnd = neg ? LIM : LIM - 1;
    end else begin
      quo = (mag <<< (WF + 1)) / den;
      rnd = (quo + 1) >>> 1;
      if (neg && rnd > LIM) rnd = LIM;
      if (!neg && rnd > LIM - 1) rnd = LIM - 1;
    end
    if (neg) rnd = -rnd;
    return rnd[OW-1:0];
  endfunction

  function automatic weight_set_t predict_weights(input logic [191:0] d);
    longint              c [NFLD];
    vec3_t               v0, v1, v2, p, n, na, nb, nc;
    logic signed [127:0] den;
    weight_set_t         r;
    int                  i;
    for (i = 0; i < NFLD; i++) c[i] = $signed(d[CB*i +: CB]);
    v0 = '{c[0], c[1], c[2]};
    v1 = '{c[3], c[4], c[5]};
    v2 = '{c[6], c[7], c[8]};
    p  = '{c[9], c[10], c[11]};
    n  = cross3(sub3(v1, v0), sub3(v2, v0));
    na = cross3(sub3(v2, v1), sub3(p, v1));
    nb = cross3(sub3(v0, v2), sub3(p, v2));
    nc = cross3(sub3(v1, v0), sub3(p, v0));
    den = dot3(n, n);
    if (den == 0) begin
      r.wa    = '0;
      r.wb    = '0;
      r.wc    = '0;
      r.degen = 1'b1;
    end else begin
      r.wa    = scale_ratio(dot3(n, na), den);
      r.wb    = scale_ratio(dot3(n, nb), den);
      r.wc    = scale_ratio(dot3(n, nc), den);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  // predict on each input transaction, compare on each output transaction
  always @(posedge clk) begin
    weight_set_t exp_w;
    weight_set_t got_w;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        weights_q.push_back(predict_weights(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_w.wa    = m_axis_tdata[0 +: OW];
        got_w.wb    = m_axis_tdata[OW +: OW];
        got_w.wc    = m_axis_tdata[2*OW +: OW];
        got_w.degen = m_axis_tuser;
        if (weights_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got a=%0d b=%0d c=%0d degen=%0b",
                   $time, $signed(got_w.wa), $signed(got_w.wb), $signed(got_w.wc),
                   got_w.degen);
        end else begin
          exp_w = weights_q.pop_front();
          checked++;
          if (exp_w.degen) degens++;
          if (got_w !== exp_w) begin
            fails++;
            $display("%0t: mismatch expected a=%0d b=%0d c=%0d degen=%0b,",
                     $time, $signed(exp_w.wa), $signed(exp_w.wb), $signed(exp_w.wc),
                     exp_w.degen);
            $display("%0t:   got a=%0d b=%0d c=%0d degen=%0b",
                     $time, $signed(got_w.wa), $signed(got_w.wb),
                     $signed(got_w.wc), got_w.degen);
          end
        end
      end
    end
    fail_cnt    <= fails;
    pending_cnt <= weights_q.size();
    checked_cnt <= checked;
    degen_cnt   <= degens;
  end

endmodule

// File: tb/barycentric_coordinates_tb.sv
module barycentric_coordinates_tb;

  localparam int CB          = bc_pkg::COORD_BITS_DEF;
  localparam int NFLD        = bc_pkg::NUM_IN_FIELDS;
  localparam int IN_W        = ((NFLD * CB + 7) / 8) * 8;
  localparam int OUT_W       = ((3 * (bc_pkg::WEIGHT_FRAC_BITS_DEF + 4) + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    Q_RANDOM,
    Q_INSIDE,
    Q_COLLINEAR,
    Q_EXTREME
  } query_kind_e;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int degen_cnt;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  int   sent_cnt       = 0;
  int   directed_cnt   = 0;
  int   cycle_cnt      = 0;

  barycentric_coordinates u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  barycentric_coordinates_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_cnt      (fail_cnt),
    .pending_cnt   (pending_cnt),
    .checked_cnt   (checked_cnt),
    .degen_cnt     (degen_cnt)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("Test completed with failures");
    $finish;
  end

  // output side: random stalls plus a long hold-off on request
  initial begin
    logic hold_seen;
    int   hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [IN_W-1:0] pack12(input shortint ax, ay, az, bx, by, bz,
                                             input shortint cx, cy, cz, px, py, pz);
    return {pz, py, px, cz, cy, cx, bz, by, bx, az, ay, ax};
  endfunction

  // one transaction on the input side, with random idle cycles ahead of it
  task automatic send_query(input logic [IN_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_cnt++;
  endtask

  function automatic int rand_signed(input int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  function automatic shortint pick_extreme();
    case ($urandom_range(5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return shortint'($urandom());
    endcase
  endfunction

  function automatic logic [IN_W-1:0] make_query(input query_kind_e kind);
    logic [IN_W-1:0] d;
    int              v [9];
    int              p [3];
    int              r, u, w, k, i;
    case (kind)
      Q_INSIDE: begin
        // well-formed triangle, point near its plane and mostly near its area
        r = ($urandom_range(3) == 0) ? 255 : 4000;
        for (i = 0; i < 9; i++) v[i] = rand_signed(r);
        u = int'($urandom_range(512)) - 128;
        w = int'($urandom_range(512)) - 128;
        for (i = 0; i < 3; i++)
          p[i] = v[i] + ((v[3+i] - v[i]) * u + (v[6+i] - v[i]) * w) / 256
                 + (($urandom_range(1) == 1) ? rand_signed(64) : 0);
        d = pack12(shortint'(v[0]), shortint'(v[1]), shortint'(v[2]),
                   shortint'(v[3]), shortint'(v[4]), shortint'(v[5]),
                   shortint'(v[6]), shortint'(v[7]), shortint'(v[8]),
                   shortint'(p[0]), shortint'(p[1]), shortint'(p[2]));
      end
      Q_COLLINEAR: begin
        // zero-area triangle: repeated or collinear vertices
        k = int'($urandom_range(5)) - 2;
        for (i = 0; i < 3; i++) begin
          v[i]   = rand_signed(8000);
          v[3+i] = v[i] + rand_signed(2000);
          v[6+i] = v[i] + k * (v[3+i] - v[i]);
          p[i]   = rand_signed(8000);
        end
        d = pack12(shortint'(v[0]), shortint'(v[1]), shortint'(v[2]),
                   shortint'(v[3]), shortint'(v[4]), shortint'(v[5]),
                   shortint'(v[6]), shortint'(v[7]), shortint'(v[8]),
                   shortint'(p[0]), shortint'(p[1]), shortint'(p[2]));
      end
      Q_EXTREME: begin
        d = pack12(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                   pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                   pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      end
      default: begin
        for (i = 0; i < IN_W / 32; i++) d[32*i +: 32] = $urandom();
      end
    endcase
    return d;
  endfunction

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    int          i, sel;
    query_kind_e kind;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) kind = Q_INSIDE;
      else if (sel < 65) kind = Q_RANDOM;
      else if (sel < 80) kind = Q_COLLINEAR;
      else kind = Q_EXTREME;
      send_query(make_query(kind));
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed queries, no idling
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // all vertices equal: degenerate at zero and both range ends
    send_query(pack12(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(pack12(32767, 32767, 32767, 32767, 32767, 32767,
                      32767, 32767, 32767, 32767, 32767, 32767));
    send_query(pack12(-32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768, -32768, -32768, -32768));
    // unit triangle in xy: vertices, centroid, edge midpoint, off the plane
    send_query(pack12(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0));
    send_query(pack12(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0));
    send_query(pack12(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, 0));
    send_query(pack12(0, 0, 0, 256, 0, 0, 0, 256, 0, 85, 85, 0));
    send_query(pack12(0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 128, 0));
    send_query(pack12(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 512));
    // far point: saturation at both ends
    send_query(pack12(0, 0, 0, 256, 0, 0, 0, 256, 0, 32767, -32768, 0));
    send_query(pack12(-32768, -32768, -32768, 32767, -32768, -32768,
                      -32768, 32767, 32767, 32767, 32767, -32768));
    // half-lsb ties, positive and negative
    send_query(pack12(-16384, -16384, 0, 16384, -16384, 0, -16384, 16384, 0,
                      -16383, -16383, 0));
    send_query(pack12(-16384, -16384, 0, 16384, -16384, 0, -16384, 16384, 0,
                      -16385, -16385, 0));
    // repeated and collinear vertices
    send_query(pack12(100, -200, 300, 100, -200, 300, 5, 6, 7, 1, 2, 3));
    send_query(pack12(0, 0, 0, 100, 200, 300, -200, -400, -600, 50, 50, 50));
    // smallest nonzero area, opposite orientation, widest spread
    send_query(pack12(0, 0, 0, 1, 0, 0, 0, 0, 1, 1, 1, 1));
    send_query(pack12(0, 0, 0, 0, 0, 256, 0, 256, 0, 0, 64, 64));
    send_query(pack12(32767, 0, -32768, -32768, 32767, 0, 0, -32768, 32767, 0, 0, 0));
    directed_cnt = sent_cnt;

    // random queries under the idling mixes
    run_random(90, 0, 0);
    run_random(90, 55, 0);
    run_random(90, 0, 55);
    run_random(90, 35, 35);
    // long output hold-off while the input keeps offering
    hold_req = ~hold_req;
    run_random(50, 0, 0);
    s_axis_tvalid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d queries (%0d directed), checked %0d results, %0d degenerate",
             sent_cnt, directed_cnt, checked_cnt, degen_cnt);
    $display("idle and stall mixes plus a %0d-cycle output hold-off were exercised",
             HOLD_CYCLES);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
